/* hdl/crs_pkg.sv */
// shared types and constants of the catmull-rom spline evaluator
`timescale 1ns / 1ps

package crs_pkg;

   localparam int COORD_W     = 32;
   localparam int PIDX_W      = 4;
   localparam int CNT_W       = 5;
   localparam int ACC_W       = 38;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int NUM_TAPS    = 4;
   localparam int AXIS_LAT    = 8;
   localparam int COUNT_MIN   = 4;

   localparam logic [CNT_W-1:0] COUNT_RESET = 5'd4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EVAL  = 1'b1
   } func_type;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_POINT_COUNT = 1'b0
   } reg_type;

endpackage

/* hdl/catmull_rom_spline_eval_top.sv */
// top level of the catmull-rom spline evaluator
// usage:
//   req channel: req_func = write stores req_coord_x/y/z in slot req_point_index;
//   req_func = eval samples the curve at req_param_t (1 << T_FRAC_BITS is 1.0).
//   rsp channel: one transfer of rsp_pos_x/y/z per eval item, none per write.
//   apb port: register 0 is point_count (4 to MAX_POINTS points in use); write it
//   only while no item is in flight, as the block does not enforce this.
// pipeline: each item passes the input register, the memory read, the
//   coefficient stage, three multiply/round pairs of horner steps and the
//   output register; throughput is one item per cycle unless held by a stall.
// the point table is kept in four copies, one per tap of the segment, so
//   all four neighbors are read in the same cycle.
// stall: while rsp_valid is high and rsp_stall is high the whole pipeline
//   holds and req_stall is high; nothing is dropped or repeated.
// reset: clears all valid bits and sets point_count to 4; the point table
//   is undefined until written.
`timescale 1ns / 1ps

module catmull_rom_spline_eval_top import crs_pkg::*; #(
   parameter int MAX_POINTS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [PIDX_W-1:0]     req_point_index,
   input  coord_type             req_coord_x,
   input  coord_type             req_coord_y,
   input  coord_type             req_coord_z,
   input  logic [T_FRAC_BITS:0]  req_param_t,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output coord_type             rsp_pos_x,
   output coord_type             rsp_pos_y,
   output coord_type             rsp_pos_z,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CAP_W   = $clog2(MAX_POINTS + 1);
   localparam int SEG_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int T_W     = T_FRAC_BITS + 1;
   localparam int PROD_W  = T_W + SEG_W;
   localparam int ENTRY_W = 3 * COORD_W;
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

   logic adv, acc;
   logic [CNT_W-1:0] cnt_ff;
   logic [SEG_W-1:0] cnt_ext, n_eff, nm1;

   // input stage
   logic             s1_vld_ff;
   func_type         s1_func_ff;
   logic [SEG_W-1:0] s1_slot_ff;
   logic [ENTRY_W-1:0] s1_data_ff;
   logic [T_W-1:0]   s1_t_ff, t_in;

   // segment selection
   logic [PROD_W-1:0]  prod;
   logic [SEG_W:0]     seg_raw;
   logic [SEG_W-1:0]   seg;
   logic [T_FRAC_BITS-1:0] s_sel;
   logic [SEG_W-1:0]   idx [NUM_TAPS];

   // table
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] rd_ff [NUM_TAPS];
   logic [T_FRAC_BITS-1:0] s2_s_ff;
   coord_type          pt_x [NUM_TAPS];
   coord_type          pt_y [NUM_TAPS];
   coord_type          pt_z [NUM_TAPS];

   logic [AXIS_LAT:0]  evl_ff;

   assign adv       = !(rsp_valid && rsp_stall);
   assign acc       = req_valid && adv;
   assign req_stall = !adv;
   assign rsp_valid = evl_ff[AXIS_LAT];

   // configuration port
   assign pready = 1'b1;

   always_comb begin
      case (reg_type'(paddr[CSR_ADDR_W-1:2]))
         REG_POINT_COUNT: prdata = CSR_DATA_W'(cnt_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= COUNT_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_type'(paddr[CSR_ADDR_W-1:2]))
            REG_POINT_COUNT: cnt_ff <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_ext = SEG_W'(cnt_ff);
      if (cnt_ext < SEG_W'(COUNT_MIN)) begin
         n_eff = SEG_W'(COUNT_MIN);
      end else if (cnt_ext > SEG_W'(MAX_POINTS)) begin
         n_eff = SEG_W'(MAX_POINTS);
      end else begin
         n_eff = cnt_ext;
      end
      nm1 = n_eff - SEG_W'(1);
   end

   assign t_in = (req_param_t > T_ONE) ? T_ONE : req_param_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff <= func_type'(req_func);
         s1_slot_ff <= SEG_W'(req_point_index);
         s1_data_ff <= {req_coord_x, req_coord_y, req_coord_z};
         s1_t_ff    <= t_in;
      end
   end

   // segment number, local parameter and the four neighbor slots
   always_comb begin
      prod    = PROD_W'(s1_t_ff) * PROD_W'(nm1);
      seg_raw = prod[PROD_W-1:T_FRAC_BITS];
      if (seg_raw >= (SEG_W+1)'(nm1)) begin
         seg   = nm1;
         s_sel = '0;
      end else begin
         seg   = seg_raw[SEG_W-1:0];
         s_sel = prod[T_FRAC_BITS-1:0];
      end
      idx[1] = seg;
      idx[0] = (seg == '0) ? seg : seg - SEG_W'(1);
      idx[2] = ((SEG_W+1)'(seg) + (SEG_W+1)'(1) >= (SEG_W+1)'(n_eff)) ?
               seg : seg + SEG_W'(1);
      idx[3] = ((SEG_W+1)'(seg) + (SEG_W+1)'(2) >= (SEG_W+1)'(n_eff)) ?
               idx[2] : seg + SEG_W'(2);
   end

   assign wr_en   = adv && s1_vld_ff && (s1_func_ff == FUNC_WRITE) &&
                    (s1_slot_ff < SEG_W'(MAX_POINTS));
   assign wr_addr = s1_slot_ff[IDX_W-1:0];

   for (genvar g = 0; g < NUM_TAPS; g++) begin : g_copy
      logic [ENTRY_W-1:0] mem [MAX_POINTS];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= s1_data_ff;
         end
         if (adv) begin
            rd_ff[g] <= mem[idx[g][IDX_W-1:0]];
         end
      end

      assign pt_x[g] = rd_ff[g][3*COORD_W-1:2*COORD_W];
      assign pt_y[g] = rd_ff[g][2*COORD_W-1:COORD_W];
      assign pt_z[g] = rd_ff[g][COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_s_ff <= s_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evl_ff <= '0;
      end else if (adv) begin
         evl_ff <= {evl_ff[AXIS_LAT-1:0], s1_vld_ff && (s1_func_ff == FUNC_EVAL)};
      end
   end

   crs_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
      .clock (clock),
      .en    (adv),
      .s     (s2_s_ff),
      .pt    (pt_x),
      .pos   (rsp_pos_x)
   );

   crs_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
      .clock (clock),
      .en    (adv),
      .s     (s2_s_ff),
      .pt    (pt_y),
      .pos   (rsp_pos_y)
   );

   crs_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_z (
      .clock (clock),
      .en    (adv),
      .s     (s2_s_ff),
      .pt    (pt_z),
      .pos   (rsp_pos_z)
   );

`ifndef SYNTHESIS
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_vld_ff && (s1_func_ff == FUNC_WRITE)) |=> !evl_ff[0])
      else $error("write transfer entered the result pipeline");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(evl_ff))
      else $error("pipeline valid bits moved under stall");

   a_taps_ordered: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && (s1_func_ff == FUNC_EVAL)) |->
      (idx[3] < n_eff && idx[0] <= idx[1] && idx[1] <= idx[2] && idx[2] <= idx[3]))
      else $error("neighbor slots out of order or beyond point count");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result held");
`endif

endmodule

/* hdl/crs_axis.sv */
// per-axis catmull-rom coefficient and horner pipeline
`timescale 1ns / 1ps

module crs_axis import crs_pkg::*; #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [T_FRAC_BITS-1:0] s,
   input  coord_type              pt [NUM_TAPS],
   output coord_type              pos
);

   localparam int S_W = T_FRAC_BITS;
   localparam int PW  = ACC_W + S_W + 1;
   localparam logic signed [PW-1:0] HALF   = PW'(1) << (S_W - 1);
   localparam acc_type              SAT_HI = ACC_W'(64'sh7FFF_FFFF);
   localparam acc_type              SAT_LO = ACC_W'(-64'sh8000_0000);

   typedef logic signed [PW-1:0] prod_type;

   function automatic prod_type mul_s(acc_type a, logic [S_W-1:0] f);
      logic signed [S_W:0] fs;
      fs = signed'({1'b0, f});
      return PW'(a) * PW'(fs);
   endfunction

   function automatic acc_type round_add(prod_type p, acc_type c);
      prod_type r;
      r = (p + HALF) >>> S_W;
      return ACC_W'(r) + c;
   endfunction

   acc_type p0, p1, p2, p3, d12;
   acc_type e3_in, e2_in, e1_in, e0_in;
   acc_type e3_ff;
   acc_type e2_ff [2];
   acc_type e1_ff [4];
   acc_type e0_ff [6];
   logic [S_W-1:0] s_ff [5];
   prod_type prod0_ff, prod1_ff, prod2_ff;
   acc_type  acc0_ff, acc1_ff, acc2_ff;
   acc_type  sum, halved;
   coord_type pos_in, pos_ff;

   // catmull-rom basis, tension one half
   always_comb begin
      p0    = ACC_W'(pt[0]);
      p1    = ACC_W'(pt[1]);
      p2    = ACC_W'(pt[2]);
      p3    = ACC_W'(pt[3]);
      d12   = p1 - p2;
      e3_in = p3 - p0 + d12 + (d12 <<< 1);
      e2_in = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
      e1_in = p2 - p0;
      e0_in = p1 <<< 1;
   end

   always_comb begin
      sum    = acc2_ff + ACC_W'(1);
      halved = sum >>> 1;
      if (halved > SAT_HI) begin
         pos_in = coord_type'(SAT_HI[COORD_W-1:0]);
      end else if (halved < SAT_LO) begin
         pos_in = coord_type'(SAT_LO[COORD_W-1:0]);
      end else begin
         pos_in = coord_type'(halved[COORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e3_ff    <= e3_in;
         e2_ff[0] <= e2_in;
         e2_ff[1] <= e2_ff[0];
         e1_ff[0] <= e1_in;
         e0_ff[0] <= e0_in;
         s_ff[0]  <= s;
         for (int k = 1; k < 4; k++) begin
            e1_ff[k] <= e1_ff[k-1];
         end
         for (int k = 1; k < 6; k++) begin
            e0_ff[k] <= e0_ff[k-1];
         end
         for (int k = 1; k < 5; k++) begin
            s_ff[k] <= s_ff[k-1];
         end
         prod0_ff <= mul_s(e3_ff, s_ff[0]);
         acc0_ff  <= round_add(prod0_ff, e2_ff[1]);
         prod1_ff <= mul_s(acc0_ff, s_ff[2]);
         acc1_ff  <= round_add(prod1_ff, e1_ff[3]);
         prod2_ff <= mul_s(acc1_ff, s_ff[4]);
         acc2_ff  <= round_add(prod2_ff, e0_ff[5]);
         pos_ff   <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule
